// File: rtl/core/hcig_pkg.sv
// Shared types, constants and codes of the hop channel index generator.
package hcig_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNTER_W = 16;
  localparam int unsigned SCR_LO_W  = 64;
  localparam int unsigned SCR_HI_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Scramble table
  localparam int unsigned TABLE_BYTES          = (SCR_LO_W + SCR_HI_W) / BYTE_W;
  localparam int unsigned DEF_SCRAMBLE_ENTRIES = 10;

  // Serial divider: widest dividend is counter times table byte plus index
  localparam int unsigned DIV_DW = COUNTER_W + BYTE_W + 1;
  localparam int unsigned DIV_VW = BYTE_W;
  localparam int unsigned DIV_CW = $clog2(DIV_DW + 1);

  // Steps per division, one quotient bit per step
  localparam logic [DIV_CW-1:0] STEPS_BYTE    = DIV_CW'(BYTE_W);
  localparam logic [DIV_CW-1:0] STEPS_COUNTER = DIV_CW'(COUNTER_W);
  localparam logic [DIV_CW-1:0] STEPS_ACC     = DIV_CW'(DIV_DW);

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] RST_CHANNEL_COUNT   = 8'd16;
  localparam logic [BYTE_W-1:0] RST_BROADCAST_COUNT = 8'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT   = 2'd0,
    CFG_BROADCAST_COUNT = 2'd1,
    CFG_SCRAMBLE_LOW    = 2'd2,
    CFG_SCRAMBLE_HIGH   = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_PERIOD_WAIT,
    ST_CLASS,
    ST_CLASS_WAIT,
    ST_SHUFFLE,
    ST_SPREAD_WAIT,
    ST_SPREAD,
    ST_LOOP,
    ST_LOOP_WAIT,
    ST_SELECT,
    ST_SELECT_REM,
    ST_ACC,
    ST_MOD,
    ST_MOD_WAIT,
    ST_DONE
  } hop_state_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_DW-1:0] quo;
    logic [DIV_VW-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/core/hcig_cfg_if.sv
// Configuration write channel of the hop channel index generator.
interface hcig_cfg_if import hcig_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/hcig_in_if.sv
// Input request channel: slot index and list counter.
interface hcig_in_if import hcig_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    slot_index;
  logic [COUNTER_W-1:0] list_counter;

  modport source (output valid, slot_index, list_counter, input ready);
  modport sink (input valid, slot_index, list_counter, output ready);
endinterface

// File: rtl/core/hcig_out_if.sv
// Result channel: hop index and broadcast flag.
interface hcig_out_if import hcig_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] hop_index;
  logic              is_broadcast;

  modport source (output valid, hop_index, is_broadcast, input ready);
  modport sink (input valid, hop_index, is_broadcast, output ready);
endinterface

// File: rtl/core/hcig_div.sv
// Restoring serial divider, one quotient bit per cycle, left-aligned dividend.
module hcig_div import hcig_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] divisor_r;

  logic [DIV_VW:0]   trial;
  logic              trial_ge;
  logic [DIV_VW:0]   trial_diff;
  logic [DIV_VW-1:0] rem_nxt;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial      = {rem_r, quo_r[DIV_DW-1]};
    trial_ge   = trial >= {1'b0, divisor_r};
    trial_diff = trial - {1'b0, divisor_r};
    rem_nxt    = trial_ge ? trial_diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
  end

  // Control: load on start, count down the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits enter at the bottom of the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_DW-2:0], trial_ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/core/hop_channel_index_generator_core.sv
// Five divisions run on the serial divider for a request when all are needed (8, 8, 8, 16
// and 25 steps); divisions are skipped when the channel or broadcast count is zero, or
// when the broadcast count exceeds the channel count.
// A new request is taken only in the idle state, once the previous result has gone to the
// result register; a stalled result holds the next one in the done state.
// Reset (synchronous, rst_n low): registers to 16 and 4 channels, zero table, zero position.
module hop_channel_index_generator_core import hcig_pkg::*; #(
  parameter int unsigned SCRAMBLE_ENTRIES = DEF_SCRAMBLE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  hcig_cfg_if.sink   cfg_req,
  hcig_in_if.sink    in_req,
  hcig_out_if.source out_res
);

  localparam int unsigned SEL_W   = (SCRAMBLE_ENTRIES > 1) ? $clog2(SCRAMBLE_ENTRIES) : 1;
  localparam int unsigned PAD_B   = DIV_DW - BYTE_W;
  localparam int unsigned PAD_C   = DIV_DW - COUNTER_W;
  localparam int unsigned PROD_W  = COUNTER_W + BYTE_W;

  // Reciprocal of the table size, exact for every 16-bit loop count
  localparam int unsigned SEL_SHIFT = 20;
  localparam int unsigned RECIP_W   = SEL_SHIFT + 1;
  localparam int unsigned SEL_PW    = COUNTER_W + RECIP_W;
  localparam logic [RECIP_W-1:0] SEL_RECIP =
    RECIP_W'(((1 << SEL_SHIFT) + SCRAMBLE_ENTRIES - 1) / SCRAMBLE_ENTRIES);
  localparam logic [COUNTER_W-1:0] SEL_DIV = COUNTER_W'(SCRAMBLE_ENTRIES);

  // Configuration registers
  logic [BYTE_W-1:0]   ch_r;
  logic [BYTE_W-1:0]   bc_r;
  logic [SCR_LO_W-1:0] scr_lo_r;
  logic [SCR_HI_W-1:0] scr_hi_r;

  // Sequencer and datapath registers
  hop_state_t           state_r, state_nxt;
  logic [BYTE_W-1:0]    slot_r;
  logic [COUNTER_W-1:0] counter_r;
  logic [BYTE_W-1:0]    period_r, period_nxt;
  logic                 bcast_r, bcast_nxt;
  logic [BYTE_W-1:0]    bcidx_r, bcidx_nxt;
  logic [BYTE_W-1:0]    pos_r, pos_nxt;
  logic [BYTE_W-1:0]    idx_r, idx_nxt;
  logic [DIV_DW-1:0]    acc_r, acc_nxt;
  logic [COUNTER_W-1:0] sel_q_r, sel_q_nxt;
  logic [SEL_W-1:0]     sel_r, sel_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_hop_r, out_hop_nxt;
  logic                 out_bc_r, out_bc_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Shared arithmetic
  logic [BYTE_W-1:0]    uni_count;
  logic [BYTE_W-1:0]    shuf_arg;
  logic [BYTE_W-1:0]    shuf_half;
  logic [BYTE_W-1:0]    shuf_v;
  logic [BYTE_W:0]      pos_inc;
  logic [COUNTER_W-1:0] mul_a;
  logic [BYTE_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [SEL_PW-1:0]    sel_prod;
  logic [COUNTER_W-1:0] sel_rem;
  logic [BYTE_W-1:0]    tbl_bytes [SCRAMBLE_ENTRIES];
  logic [BYTE_W-1:0]    tbl_byte;
  logic                 in_take;

  hcig_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Scramble table bytes, byte 0 in the lowest bits
  for (genvar k = 0; k < SCRAMBLE_ENTRIES; k++) begin : g_tbl
    assign tbl_bytes[k] = (k < SCR_LO_W / BYTE_W) ?
                          scr_lo_r[(k % (SCR_LO_W / BYTE_W)) * BYTE_W +: BYTE_W] :
                          scr_hi_r[(k % (SCR_HI_W / BYTE_W)) * BYTE_W +: BYTE_W];
  end
  assign tbl_byte = tbl_bytes[sel_r];

  // Shuffle: interleave even and odd indexes below the unicast count
  always_comb begin
    uni_count = ch_r - bc_r;
    shuf_arg  = bcast_r ? (uni_count + bcidx_r) : pos_r;
    shuf_half = {1'b0, shuf_arg[BYTE_W-1:1]};
    shuf_v    = shuf_arg;
    if ((bc_r <= ch_r) && (shuf_arg < uni_count)) begin
      shuf_v = shuf_arg[0] ? (uni_count - 8'd1 - shuf_half) : shuf_half;
    end
    pos_inc = {1'b0, pos_r} + 9'd1;
  end

  // Shared multiplier, operands picked by state
  always_comb begin
    if (state_r == ST_ACC) begin
      mul_a = counter_r;
      mul_b = tbl_byte;
    end else begin
      mul_a = {{(COUNTER_W-BYTE_W){1'b0}}, div_rsp.rem};
      mul_b = period_r;
    end
    mul_p = {{BYTE_W{1'b0}}, mul_a} * {{COUNTER_W{1'b0}}, mul_b};
  end

  // Table select: loop count modulo table entries by reciprocal multiplication
  always_comb begin
    sel_prod = {{RECIP_W{1'b0}}, div_rsp.quo[COUNTER_W-1:0]} *
               {{COUNTER_W{1'b0}}, SEL_RECIP};
    sel_rem  = div_rsp.quo[COUNTER_W-1:0] - sel_q_r * SEL_DIV;
  end

  assign in_take = in_req.valid && (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:        if (in_req.valid) state_nxt = (bc_r != '0) ? ST_PERIOD : ST_CLASS;
      ST_PERIOD:      state_nxt = ST_PERIOD_WAIT;
      ST_PERIOD_WAIT: if (!div_rsp.busy) state_nxt = ST_CLASS;
      ST_CLASS:       state_nxt = (period_r != '0) ? ST_CLASS_WAIT : ST_SHUFFLE;
      ST_CLASS_WAIT:  if (!div_rsp.busy) state_nxt = ST_SHUFFLE;
      ST_SHUFFLE:     state_nxt = (bc_r != '0) ? ST_SPREAD_WAIT : ST_LOOP;
      ST_SPREAD_WAIT: if (!div_rsp.busy) state_nxt = ST_SPREAD;
      ST_SPREAD:      state_nxt = ST_LOOP;
      ST_LOOP:        state_nxt = (ch_r != '0) ? ST_LOOP_WAIT : ST_DONE;
      ST_LOOP_WAIT:   if (!div_rsp.busy) state_nxt = ST_SELECT;
      ST_SELECT:      state_nxt = ST_SELECT_REM;
      ST_SELECT_REM:  state_nxt = ST_ACC;
      ST_ACC:         state_nxt = ST_MOD;
      ST_MOD:         state_nxt = ST_MOD_WAIT;
      ST_MOD_WAIT:    if (!div_rsp.busy) state_nxt = ST_DONE;
      ST_DONE:        if (!out_valid_r || out_res.ready) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: divider requests and datapath updates
  always_comb begin
    div_req       = '0;
    period_nxt    = period_r;
    bcast_nxt     = bcast_r;
    bcidx_nxt     = bcidx_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    sel_q_nxt     = sel_q_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_hop_nxt   = out_hop_r;
    out_bc_nxt    = out_bc_r;
    unique case (state_r)
      ST_IDLE: begin
        period_nxt = '0;
      end
      ST_PERIOD: begin
        // channels per broadcast slot
        div_req.start    = 1'b1;
        div_req.dividend = {ch_r, {PAD_B{1'b0}}};
        div_req.divisor  = bc_r;
        div_req.steps    = STEPS_BYTE;
      end
      ST_PERIOD_WAIT: begin
        if (!div_rsp.busy) period_nxt = div_rsp.quo[BYTE_W-1:0];
      end
      ST_CLASS: begin
        bcast_nxt = 1'b1;
        bcidx_nxt = '0;
        if (period_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {slot_r, {PAD_B{1'b0}}};
          div_req.divisor  = period_r;
          div_req.steps    = STEPS_BYTE;
        end
      end
      ST_CLASS_WAIT: begin
        if (!div_rsp.busy) begin
          bcast_nxt = (div_rsp.rem == '0);
          bcidx_nxt = div_rsp.quo[BYTE_W-1:0];
        end
      end
      ST_SHUFFLE: begin
        // advance and wrap the unicast position
        if (!bcast_r) begin
          pos_nxt = (pos_inc >= {1'b0, uni_count}) ? '0 : pos_inc[BYTE_W-1:0];
        end
        idx_nxt = shuf_v;
        if (bc_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {shuf_v, {PAD_B{1'b0}}};
          div_req.divisor  = bc_r;
          div_req.steps    = STEPS_BYTE;
        end
      end
      ST_SPREAD_WAIT: begin
      end
      ST_SPREAD: begin
        // spread: remainder times period plus quotient
        idx_nxt = mul_p[BYTE_W-1:0] + div_rsp.quo[BYTE_W-1:0];
      end
      ST_LOOP: begin
        if (ch_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {counter_r, {PAD_C{1'b0}}};
          div_req.divisor  = ch_r;
          div_req.steps    = STEPS_COUNTER;
        end else begin
          idx_nxt = '0;
        end
      end
      ST_LOOP_WAIT: begin
      end
      ST_SELECT: begin
        // table select: quotient of the loop count by the table size
        sel_q_nxt = sel_prod[SEL_SHIFT +: COUNTER_W];
      end
      ST_SELECT_REM: begin
        // hold the remainder as the table entry
        sel_nxt = sel_rem[SEL_W-1:0];
      end
      ST_ACC: begin
        acc_nxt = {1'b0, mul_p} + {{(DIV_DW-BYTE_W){1'b0}}, idx_r};
      end
      ST_MOD: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc_r;
        div_req.divisor  = ch_r;
        div_req.steps    = STEPS_ACC;
      end
      ST_MOD_WAIT: begin
        if (!div_rsp.busy) idx_nxt = div_rsp.rem;
      end
      ST_DONE: begin
        // load the result register once it is free
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_hop_nxt   = idx_r;
          out_bc_nxt    = bcast_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= RST_CHANNEL_COUNT;
      bc_r     <= RST_BROADCAST_COUNT;
      scr_lo_r <= '0;
      scr_hi_r <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        CFG_CHANNEL_COUNT:   ch_r     <= cfg_req.data[BYTE_W-1:0];
        CFG_BROADCAST_COUNT: bc_r     <= cfg_req.data[BYTE_W-1:0];
        CFG_SCRAMBLE_LOW:    scr_lo_r <= cfg_req.data[SCR_LO_W-1:0];
        CFG_SCRAMBLE_HIGH:   scr_hi_r <= cfg_req.data[SCR_HI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_r    <= in_req.slot_index;
      counter_r <= in_req.list_counter;
    end
    period_r  <= period_nxt;
    bcast_r   <= bcast_nxt;
    bcidx_r   <= bcidx_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    sel_q_r   <= sel_q_nxt;
    sel_r     <= sel_nxt;
    out_hop_r <= out_hop_nxt;
    out_bc_r  <= out_bc_nxt;
  end

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.hop_index    = out_hop_r;
  assign out_res.is_broadcast = out_bc_r;

`ifndef SYNTHESIS
  // Result stays below a nonzero channel count
  a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ch_r != 8'd0)) |-> (out_hop_r < ch_r))
    else $error("hop index not below channel count");

  // No channels gives index zero
  a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ch_r == 8'd0)) |-> (out_hop_r == 8'd0))
    else $error("nonzero hop index with no channels");

  // Divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Unicast position moves only after a unicast shuffle
  a_pos_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(pos_r)) |-> (($past(state_r) == ST_SHUFFLE) && !$past(bcast_r)))
    else $error("unicast position changed outside unicast shuffle");

  // A new result appears only from the done state
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result valid raised outside done state");
`endif

endmodule

// File: tb/hop_channel_index_generator_core_tb.sv
// Self-checking testbench for the hop channel index generator core.
module hop_channel_index_generator_core_tb import hcig_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = DEF_SCRAMBLE_ENTRIES;
  localparam int unsigned PHASES        = 13;
  localparam int unsigned RANDOM_ITEMS  = 92;
  localparam int unsigned IDLE_PCT      = 26;
  localparam int unsigned DRAIN_CYCLES  = 120;

  typedef struct packed {
    logic [BYTE_W-1:0] hop_index;
    logic              is_broadcast;
  } hop_result_t;

  // Tracks the channel plan and unicast position, predicts each hop
  class hop_scoreboard;
    logic [BYTE_W-1:0]   chan_cnt;
    logic [BYTE_W-1:0]   bcast_cnt;
    logic [SCR_LO_W-1:0] scr_lo;
    logic [SCR_HI_W-1:0] scr_hi;
    logic [BYTE_W-1:0]   uni_pos;
    hop_result_t         expected_hops[$];
    int unsigned         errors;

    function new();
      chan_cnt  = RST_CHANNEL_COUNT;
      bcast_cnt = RST_BROADCAST_COUNT;
      scr_lo    = '0;
      scr_hi    = '0;
      uni_pos   = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNEL_COUNT:   chan_cnt  = data[BYTE_W-1:0];
        CFG_BROADCAST_COUNT: bcast_cnt = data[BYTE_W-1:0];
        CFG_SCRAMBLE_LOW:    scr_lo    = data[SCR_LO_W-1:0];
        CFG_SCRAMBLE_HIGH:   scr_hi    = data[SCR_HI_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the hop for one accepted request and queue it
    function void predict_hop(logic [BYTE_W-1:0] slot, logic [COUNTER_W-1:0] cnt);
      int unsigned ch, bc, period, u, v, nxt, sel, acc;
      logic [SCR_HI_W+SCR_LO_W-1:0] tbl;
      hop_result_t res;
      ch     = chan_cnt;
      bc     = bcast_cnt;
      period = (bc != 0) ? ch / bc : 0;
      u      = ch - bc;
      res.is_broadcast = (period == 0) || ((slot % period) == 0);
      // Pick the index to shuffle; unicast slots advance the kept position
      if (res.is_broadcast) begin
        v = (u + ((period != 0) ? slot / period : 0)) & 32'hFF;
      end else begin
        v   = uni_pos;
        nxt = uni_pos + 1;
        if (nxt >= u) nxt = 0;
        uni_pos = nxt[BYTE_W-1:0];
      end
      // Interleave even and odd indexes below the unicast span
      if (bc <= ch && v < u) begin
        if (v[0] == 1'b0) v = v / 2;
        else v = (u - 1 - v / 2) & 32'hFF;
      end
      // Spread the broadcast channels
      if (bc != 0) v = ((v % bc) * (ch / bc) + v / bc) & 32'hFF;
      // Scramble with the list counter
      if (ch == 0) begin
        res.hop_index = '0;
      end else begin
        tbl = {scr_hi, scr_lo};
        sel = (cnt / ch) % TABLE_ENTRIES;
        acc = cnt * tbl[sel*8 +: 8] + v;
        res.hop_index = 8'(acc % ch);
      end
      expected_hops.push_back(res);
    endfunction

    function void check_hop(hop_result_t got);
      hop_result_t exp_res;
      if (expected_hops.size() == 0) begin
        $error("unexpected result: hop_index %0d is_broadcast %0d",
               got.hop_index, got.is_broadcast);
        errors++;
      end else begin
        exp_res = expected_hops.pop_front();
        if (got.hop_index !== exp_res.hop_index) begin
          $error("hop_index expected %0d actual %0d", exp_res.hop_index, got.hop_index);
          errors++;
        end
        if (got.is_broadcast !== exp_res.is_broadcast) begin
          $error("is_broadcast expected %0d actual %0d",
                 exp_res.is_broadcast, got.is_broadcast);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hops.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;

  hcig_cfg_if cfg_bus ();
  hcig_in_if  in_bus ();
  hcig_out_if out_bus ();

  hop_scoreboard sb = new();

  hop_channel_index_generator_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_req (cfg_bus),
    .in_req  (in_bus),
    .out_res (out_bus)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls at random, except in calm stretches
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Observe every handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(cfg_reg_t'(cfg_bus.index), cfg_bus.data);
      if (in_bus.valid && in_bus.ready)
        sb.predict_hop(in_bus.slot_index, in_bus.list_counter);
      if (out_bus.valid && out_bus.ready)
        sb.check_hop('{hop_index: out_bus.hop_index, is_broadcast: out_bus.is_broadcast});
    end
  end

  // Write all four registers back to back, then drop valid
  task automatic write_config(logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] bc,
                              logic [SCR_LO_W-1:0] lo, logic [SCR_HI_W-1:0] hi);
    cfg_reg_t idx;
    for (int r = 0; r < 4; r++) begin
      idx = cfg_reg_t'(r);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      case (idx)
        CFG_CHANNEL_COUNT:   cfg_bus.data <= CFG_DATA_W'(ch);
        CFG_BROADCAST_COUNT: cfg_bus.data <= CFG_DATA_W'(bc);
        CFG_SCRAMBLE_LOW:    cfg_bus.data <= CFG_DATA_W'(lo);
        default:             cfg_bus.data <= CFG_DATA_W'(hi);
      endcase
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Send one request; valid stays high into the next one unless an idle gap falls
  task automatic send_request(logic [BYTE_W-1:0] slot, logic [COUNTER_W-1:0] cnt);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid        <= 1'b1;
    in_bus.slot_index   <= slot;
    in_bus.list_counter <= cnt;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Hold off until every expected hop has come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Channel plans: reset plan, extremes, zero counts, broadcast above total,
  // position left beyond the unicast span, broadcast argument overflow
  logic [BYTE_W-1:0] plan_ch [PHASES] = '{8'd16, 8'd255, 8'd16, 8'd1, 8'd255, 8'd0, 8'd40,
                                          8'd3, 8'd200, 8'd10, 8'd255, 8'd64, 8'd17};
  logic [BYTE_W-1:0] plan_bc [PHASES] = '{8'd4, 8'd1, 8'd4, 8'd1, 8'd255, 8'd0, 8'd0,
                                          8'd200, 8'd7, 8'd3, 8'd128, 8'd8, 8'd5};

  // Stimulus
  initial begin
    logic [SCR_LO_W-1:0]  lo;
    logic [SCR_HI_W-1:0]  hi;
    logic [COUNTER_W-1:0] cnt;
    rst_n               <= 1'b0;
    calm                 = 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_CHANNEL_COUNT;
    cfg_bus.data        <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.slot_index   <= '0;
    in_bus.list_counter <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Phase zero runs on the reset plan
      if (p != 0) begin
        case (p)
          1:       begin lo = '1; hi = '1; end
          11:      begin lo = '0; hi = '0; end
          12:      begin lo = {$urandom, $urandom}; hi = '0; end
          default: begin lo = {$urandom, $urandom}; hi = 16'($urandom); end
        endcase
        write_config(plan_ch[p], plan_bc[p], lo, hi);
      end
      calm = (p == 8);

      // Field extremes
      send_request(8'hFF, 16'hFFFF);
      send_request(8'h00, 16'h0000);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) cnt = 16'($urandom_range(0, 255));
        else cnt = 16'($urandom_range(0, 65535));
        send_request(8'($urandom_range(0, 255)), cnt);
        if (p == 2 && i == 40) drain();
      end
      drain();
    end

    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
